// ===== rtl/core/variable_length_bit_packer_core_assert.svh =====
// assertion macros for the bit packer core
`ifndef VARIABLE_LENGTH_BIT_PACKER_CORE_ASSERT_SVH
`define VARIABLE_LENGTH_BIT_PACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define VLBP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// clocked check, active during reset as well
`define VLBP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define VLBP_ASSERT(lbl, clk, rst_n, prop, msg)
`define VLBP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== rtl/core/vlbp_pkg.sv =====
// shared constants and types for the bit packer core
package vlbp_pkg;

	localparam int CODE_W  = 32;
	localparam int LEN_W   = 6;
	localparam int BYTE_W  = 8;
	localparam int SH_W    = $clog2(CODE_W);
	localparam int Q_DEPTH = 4;

	localparam logic CMD_APPEND = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef struct packed {
		logic full;
		logic empty;
	} vlbp_qstat_t;

endpackage

// ===== rtl/core/vlbp_front.sv =====
// front stage: holds the partial byte, merges each item and queues byte jobs
module vlbp_front #(
	parameter int MAX_CODE_BITS = 32,
	parameter int ACC_W         = 32,
	parameter int CNT_W         = 3
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       command,
	input  logic [vlbp_pkg::CODE_W-1:0] code_bits,
	input  logic [vlbp_pkg::LEN_W-1:0]  code_length,
	input  vlbp_pkg::vlbp_qstat_t      qstat,
	output logic                       push,
	output logic [ACC_W-1:0]           push_acc,
	output logic [CNT_W-1:0]           push_cnt
);
	import vlbp_pkg::*;

	localparam int WIDE_W = ACC_W + CODE_W + BYTE_W;
	localparam int TOT_W  = LEN_W + 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CODE_BITS);

	logic [BYTE_W-1:0] pending_q;
	logic [2:0]        fill_q;

	logic              accept;
	logic [LEN_W-1:0]  len_sat;
	logic [CODE_W-1:0] code_mask;
	logic [WIDE_W-1:0] wide;
	logic [WIDE_W-1:0] rest;
	logic [TOT_W-1:0]  total;
	logic [TOT_W-4:0]  nbytes;

	assign in_ready = !qstat.full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		len_sat   = (code_length > MAX_LEN) ? MAX_LEN : code_length;
		code_mask = (len_sat >= LEN_W'(CODE_W)) ? {CODE_W{1'b1}}
			: ~({CODE_W{1'b1}} << len_sat[SH_W-1:0]);
		wide      = WIDE_W'(pending_q) | (WIDE_W'(code_bits & code_mask) << fill_q);
		total     = TOT_W'(fill_q) + TOT_W'(len_sat);
		nbytes    = total[TOT_W-1:3];
		rest      = wide >> {nbytes, 3'b000};
	end

	always_comb begin
		unique case (command)
			CMD_APPEND: begin
				push     = accept && (nbytes != '0);
				push_acc = wide[ACC_W-1:0];
				push_cnt = CNT_W'(nbytes);
			end
			CMD_FLUSH: begin
				push     = accept && (fill_q != '0);
				push_acc = ACC_W'(pending_q);
				push_cnt = CNT_W'(1);
			end
			default: begin
				push     = 1'b0;
				push_acc = '0;
				push_cnt = '0;
			end
		endcase
	end

	// flush leaves the partial byte untouched
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
			fill_q    <= '0;
		end else if (accept && command == CMD_APPEND) begin
			pending_q <= rest[BYTE_W-1:0];
			fill_q    <= total[2:0];
		end
	end

endmodule

// ===== rtl/core/vlbp_queue.sv =====
// short job queue between the front and back stages
module vlbp_queue #(
	parameter int WIDTH = 35
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  logic [WIDTH-1:0]      push_data,
	input  logic                  pop,
	output logic [WIDTH-1:0]      head_data,
	output vlbp_pkg::vlbp_qstat_t qstat
);
	import vlbp_pkg::*;

	`include "variable_length_bit_packer_core_assert.svh"

	localparam int PTR_W = $clog2(Q_DEPTH);
	localparam int CNT_W = $clog2(Q_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [Q_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign qstat.full  = (count_q == CNT_W'(Q_DEPTH));
	assign qstat.empty = (count_q == '0);
	assign do_push     = push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head_data   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(do_push) - CNT_W'(do_pop);
		end
	end

	`VLBP_ASSERT(a_no_push_full, clk, arst_n, !(push && qstat.full), "push into full queue")
	`VLBP_ASSERT(a_no_pop_empty, clk, arst_n, !(pop && qstat.empty), "pop from empty queue")
	`VLBP_ASSERT(a_count_track, clk, arst_n, $past(arst_n) |-> (count_q == $past(count_q) + CNT_W'($past(do_push)) - CNT_W'($past(do_pop))), "queue fill count mismatch")

endmodule

// ===== rtl/core/vlbp_back.sv =====
// back stage: walks the head job byte by byte into the output register
module vlbp_back #(
	parameter int ACC_W = 32,
	parameter int CNT_W = 3,
	parameter int IDX_W = 2
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  vlbp_pkg::vlbp_qstat_t      qstat,
	input  logic [ACC_W-1:0]           head_acc,
	input  logic [CNT_W-1:0]           head_cnt,
	output logic                       pop,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [vlbp_pkg::BYTE_W-1:0] out_byte,
	output logic                       last
);
	import vlbp_pkg::*;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              last_q;
	logic [IDX_W-1:0]  idx_q;
	logic              emit;
	logic              is_last;
	logic [ACC_W-1:0]  sel;

	assign emit    = !qstat.empty && (!out_valid_q || out_ready);
	assign is_last = (idx_q == IDX_W'(head_cnt - CNT_W'(1)));
	assign sel     = head_acc >> {idx_q, 3'b000};
	assign pop     = emit && is_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
				idx_q       <= is_last ? '0 : idx_q + IDX_W'(1);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= sel[BYTE_W-1:0];
			last_q     <= is_last;
		end
	end

endmodule

// ===== rtl/core/variable_length_bit_packer_core.sv =====
// top level of the lsb-first variable-length bit packer
//
//  channel  | signals                                 | role
//  ---------+-----------------------------------------+------------------------------
//  input    | in_valid in_ready command code_bits     | one append or flush per
//           | code_length                             | transfer
//  output   | out_valid out_ready out_byte last       | one packed byte per transfer
//
// an item is taken every cycle while the job queue has room; the front merges
// it with the partial byte in the same cycle, so back-to-back appends never wait
// on each other
// the back stage sends one byte per cycle while the output is not stalled;
// an item's n bytes leave in turn, and the four-entry job queue soaks up such bursts
// with the queue empty and the output free, the first byte of an item passes
// through the job queue and then the output register before it is valid
// reset clears the partial byte, the bit offset, the queue and out_valid
// output stalls back up through the queue to in_ready only when all four
// entries are waiting
module variable_length_bit_packer_core #(
	parameter int MAX_CODE_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        command,
	input  logic [vlbp_pkg::CODE_W-1:0] code_bits,
	input  logic [vlbp_pkg::LEN_W-1:0]  code_length,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [vlbp_pkg::BYTE_W-1:0] out_byte,
	output logic                        last
);
	import vlbp_pkg::*;

	// most bytes one append can complete, partial bits included
	localparam int MAX_BYTES = (7 + MAX_CODE_BITS) / 8;
	localparam int ACC_W     = 8 * MAX_BYTES;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int IDX_W     = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
	localparam int JOB_W     = ACC_W + CNT_W;

	// job handed from front to back: merged bits plus number of full bytes
	logic              push;
	logic [ACC_W-1:0]  push_acc;
	logic [CNT_W-1:0]  push_cnt;
	logic              pop;
	logic [JOB_W-1:0]  head_data;
	vlbp_qstat_t       qstat;

	// front: partial byte state and merge
	vlbp_front #(
		.MAX_CODE_BITS(MAX_CODE_BITS),
		.ACC_W(ACC_W),
		.CNT_W(CNT_W)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.code_bits(code_bits),
		.code_length(code_length),
		.qstat(qstat),
		.push(push),
		.push_acc(push_acc),
		.push_cnt(push_cnt)
	);

	// decoupling queue, job stored as {bits, count}
	vlbp_queue #(
		.WIDTH(JOB_W)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data({push_acc, push_cnt}),
		.pop(pop),
		.head_data(head_data),
		.qstat(qstat)
	);

	// back: byte serializer with registered output
	vlbp_back #(
		.ACC_W(ACC_W),
		.CNT_W(CNT_W),
		.IDX_W(IDX_W)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.head_acc(head_data[JOB_W-1:CNT_W]),
		.head_cnt(head_data[CNT_W-1:0]),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last(last)
	);

endmodule
